FILE: src/missing_in_range_bitmap_defines.svh
// Assertion macros used by the verification file of the missing-number block.
// No dependencies.
`ifndef MISSING_IN_RANGE_BITMAP_DEFINES_SVH
`define MISSING_IN_RANGE_BITMAP_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define MIRB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error("mirb check failed");

// check a property on every rising clock edge, reset included
`define MIRB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) else $error("mirb check failed");

`endif

FILE: src/mirb_pkg.sv
// Shared types and constants of the missing-number bitmap block.
// No dependencies; used by the front, back and top-level modules of the block.
package mirb_pkg;

   localparam int REG_W   = 6;
   localparam int NUM_W   = 6;
   localparam int VALUE_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic [REG_W-1:0] RANGE_LOW_RESET  = 6'd0;
   localparam logic [REG_W-1:0] RANGE_HIGH_RESET = 6'd63;

   typedef enum logic {
      REG_RANGE_LOW  = 1'b0,
      REG_RANGE_HIGH = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_VALUE = 1'b0,
      OP_END   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_EVAL,
      BK_DONE
   } back_state_type;

endpackage

FILE: src/mirb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mirb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/mirb_fifo.sv
// Small queue between the classifying front end and the bitmap back end.
// No dependencies.
module mirb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/mirb_front.sv
// Front end: takes request words, drops values outside the range, queues the rest.
// Depends on mirb_pkg.
module mirb_front #(
   parameter int AW = 6
) (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [mirb_pkg::VALUE_W-1:0] req_tdata,
   input  logic                        req_tlast,
   input  logic [AW-1:0]               lo,
   input  logic [AW-1:0]               hi,
   input  logic                        clearing,
   input  logic                        fifo_full,
   output logic                        push,
   output logic [AW:0]                 push_data
);
   import mirb_pkg::*;

   logic               accept;
   logic               is_end;
   logic               in_range;
   logic [VALUE_W-1:0] lo_ext, hi_ext;

   assign lo_ext   = VALUE_W'(lo);
   assign hi_ext   = VALUE_W'(hi);
   assign is_end   = (op_type'(req_tlast) == OP_END);
   assign in_range = !req_tdata[VALUE_W-1] && (req_tdata >= lo_ext) && (req_tdata <= hi_ext);

   assign req_tready = !fifo_full && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (is_end || in_range);
   assign push_data  = {is_end, req_tdata[AW-1:0]};

endmodule

FILE: src/mirb_back.sv
// Back end: marks the bitmap, scans it on an end word, drives the result register and clears the bitmap.
// Depends on mirb_pkg; drives one mirb_ram through its port signals.
module mirb_back #(
   parameter int VALUE_SPACE = 64,
   parameter int AW = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [AW-1:0]                 lo,
   input  logic [AW-1:0]                 hi,
   input  logic                          fifo_empty,
   input  logic [AW:0]                   fifo_data,
   output logic                          fifo_pop,
   output logic                          clearing,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic                          ram_wdata,
   output logic                          ram_re,
   output logic [AW-1:0]                 ram_raddr,
   input  logic                          ram_rdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mirb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import mirb_pkg::*;

   localparam logic [AW-1:0] MAX_IDX = AW'(VALUE_SPACE - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    pend_ff, pend_in;
   logic             pend_v_ff, pend_v_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             out_free;
   logic             missing;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign missing  = !ram_rdata;
   assign clearing = (state_ff == BK_CLEAR);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      fifo_pop     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff;
      ram_wdata    = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = cur_ff;
      case (state_ff)
         BK_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == MAX_IDX) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               if (fifo_data[AW]) begin
                  pend_v_in = 1'b0;
                  cur_in    = lo;
                  state_in  = (lo <= hi) ? BK_READ : BK_DONE;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = fifo_data[AW-1:0];
                  ram_wdata = 1'b1;
               end
            end
         end
         BK_READ: begin
            ram_re   = 1'b1;
            state_in = BK_EVAL;
         end
         BK_EVAL: begin
            if (!(missing && pend_v_ff && !out_free)) begin
               ram_we = 1'b1;
               if (missing) begin
                  if (pend_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_num_in   = NUM_W'(pend_ff);
                     rsp_last_in  = 1'b0;
                     rsp_empty_in = 1'b0;
                  end
                  pend_in   = cur_ff;
                  pend_v_in = 1'b1;
               end
               if (cur_ff == hi) begin
                  state_in = BK_DONE;
               end else begin
                  cur_in   = cur_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = pend_v_ff ? NUM_W'(pend_ff) : '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = !pend_v_ff;
               pend_v_in    = 1'b0;
               clr_cnt_in   = '0;
               state_in     = BK_CLEAR;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      pend_ff      <= pend_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_num_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

FILE: src/missing_in_range_bitmap.sv
// Top level of the missing-number bitmap block: range registers, front, queue, back, RAM.
// Depends on mirb_pkg, mirb_front, mirb_fifo, mirb_back and mirb_ram.
//
// Value words mark their number in a presence bitmap when it lies within
// range_low..range_high (bounds saturate to VALUE_SPACE-1); other values are dropped.
// Words may arrive every cycle while the queue is not full and no clearing pass runs.
// An end word (tlast high) starts a scan of the range in the bitmap RAM: a read state
// and an evaluate state per range number, set by the RAM's registered read, then a done
// state; the scan can stall while rsp_tready is low. Each missing number leaves as one
// rsp word in ascending order, the last with tlast; with nothing missing one word with
// tuser set and number 0 is sent. A four-entry queue keeps accepting words during a
// scan until it is full. After reset, and again after the last rsp word of each end word
// is registered, a clearing pass over every bitmap entry runs with req_tready low.
module missing_in_range_bitmap #(
   parameter int VALUE_SPACE = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: value[31:0]; tlast: op (end of sequence)
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mirb_pkg::VALUE_W-1:0]     req_tdata,
   input  logic                             req_tlast,
   // tdata: number[5:0], zero[7:6]; tlast: last; tuser: empty_res
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mirb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [mirb_pkg::REG_W-1:0]       csr_wdata
);
   import mirb_pkg::*;

   localparam int          AW         = $clog2(VALUE_SPACE);
   localparam int          FIFO_DEPTH = 4;
   localparam logic [31:0] MAX_BOUND  = 32'(VALUE_SPACE - 1);

   logic [REG_W-1:0] range_low_ff, range_low_in;
   logic [REG_W-1:0] range_high_ff, range_high_in;
   logic [31:0]      low_ext, high_ext;
   logic [31:0]      low_sat, high_sat;
   logic [AW-1:0]    lo, hi;
   logic             clearing;
   logic             fifo_full, fifo_empty, fifo_push, fifo_pop;
   logic [AW:0]      fifo_push_data, fifo_pop_data;
   logic             ram_we, ram_re, ram_wdata, ram_rdata;
   logic [AW-1:0]    ram_waddr, ram_raddr;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_RANGE_LOW:  range_low_in  = csr_wdata;
            REG_RANGE_HIGH: range_high_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   assign low_ext  = 32'(range_low_ff);
   assign high_ext = 32'(range_high_ff);
   assign low_sat  = (low_ext > MAX_BOUND) ? MAX_BOUND : low_ext;
   assign high_sat = (high_ext > MAX_BOUND) ? MAX_BOUND : high_ext;
   assign lo       = low_sat[AW-1:0];
   assign hi       = high_sat[AW-1:0];

   mirb_front #(
      .AW (AW)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .lo         (lo),
      .hi         (hi),
      .clearing   (clearing),
      .fifo_full  (fifo_full),
      .push       (fifo_push),
      .push_data  (fifo_push_data)
   );

   mirb_fifo #(
      .WIDTH (AW + 1),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_pop_data),
      .empty     (fifo_empty)
   );

   mirb_back #(
      .VALUE_SPACE (VALUE_SPACE),
      .AW          (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .lo         (lo),
      .hi         (hi),
      .fifo_empty (fifo_empty),
      .fifo_data  (fifo_pop_data),
      .fifo_pop   (fifo_pop),
      .clearing   (clearing),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   mirb_ram #(
      .WIDTH (1),
      .DEPTH (VALUE_SPACE)
   ) u_seen_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

FILE: src/mirb_checker.sv
// Port-level checks of the missing-number bitmap block, bound to its top level.
// Depends on mirb_pkg and missing_in_range_bitmap_defines.svh.
`include "missing_in_range_bitmap_defines.svh"

module mirb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mirb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);
   import mirb_pkg::*;

   `MIRB_ASSERT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `MIRB_ASSERT(empty_is_last_a, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast)
   `MIRB_ASSERT(empty_number_zero_a, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
   `MIRB_ASSERT_ALWAYS(clear_after_reset_a, clock, reset |=> !req_tready && !rsp_tvalid)

endmodule

bind missing_in_range_bitmap mirb_checker u_mirb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
